>>> sv/qau_pkg.sv
// Package: widths, stage map, command codes, CORDIC table and rounding helpers.
package qau_pkg;

  localparam int COMP_WIDTH   = 16;
  localparam int FRAC_BITS    = COMP_WIDTH - 2;
  localparam int PROD_W       = 2 * COMP_WIDTH;
  localparam int PSUM_W       = PROD_W + 2;
  localparam int SSUM_W       = PROD_W + 1;
  localparam int ROOT_W       = COMP_WIDTH + 1;
  localparam int SQRT_W       = SSUM_W + 1;
  localparam int SQRT_STEPS   = ROOT_W;
  localparam int QUO_W        = COMP_WIDTH - 1;
  localparam int DIV_STEPS    = QUO_W;
  localparam int NUM_W        = COMP_WIDTH + FRAC_BITS;
  localparam int ANGLE_W      = 16;
  localparam int ANGLE_SHIFT  = 15;
  localparam int CORDIC_STEPS = 24;
  localparam int CORDIC_W     = 34;
  localparam int CORDIC_FRAC  = 30;
  localparam int CQ_SHIFT     = CORDIC_FRAC - FRAC_BITS;
  localparam int CQ_W         = CORDIC_W - CQ_SHIFT;
  localparam int ONE_Q        = 1 << FRAC_BITS;

  localparam int ST_SQRT_IN = 2;
  localparam int ST_DIV_IN  = ST_SQRT_IN + SQRT_STEPS;
  localparam int ST_LAST    = ST_DIV_IN + DIV_STEPS;
  localparam int ST_COR_OUT = ST_SQRT_IN + CORDIC_STEPS;

  localparam logic [1:0] CMD_MUL  = 2'd0;
  localparam logic [1:0] CMD_NORM = 2'd1;
  localparam logic [1:0] CMD_CONJ = 2'd2;
  localparam logic [1:0] CMD_AXIS = 2'd3;

  typedef logic signed [COMP_WIDTH-1:0] comp_t;
  typedef logic signed [PROD_W-1:0]     prod_t;
  typedef logic signed [PSUM_W-1:0]     psum_t;
  typedef logic signed [CORDIC_W-1:0]   cval_t;

  localparam comp_t COMP_MAX = {1'b0, {(COMP_WIDTH-1){1'b1}}};
  localparam comp_t COMP_MIN = {1'b1, {(COMP_WIDTH-1){1'b0}}};

  localparam cval_t CORDIC_GAIN = CORDIC_W'(652032874);

  localparam logic [31:0] ATAN_TURNS [CORDIC_STEPS] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
    32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
    32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
  };

  typedef struct {
    logic [1:0] cmd;
    comp_t      a     [4];
    comp_t      rmul  [4];
    comp_t      rconj [4];
  } pass_t;

  // Round half up to the component grid and saturate.
  function automatic comp_t round_sat(input psum_t p);
    psum_t                          t;
    logic [PSUM_W-FRAC_BITS-1:0]    q;
    t = p + (PSUM_W'(1) << (FRAC_BITS - 1));
    q = t[PSUM_W-1:FRAC_BITS];
    if ((&q[PSUM_W-FRAC_BITS-1:COMP_WIDTH-1]) || !(|q[PSUM_W-FRAC_BITS-1:COMP_WIDTH-1])) begin
      return q[COMP_WIDTH-1:0];
    end
    return q[PSUM_W-FRAC_BITS-1] ? COMP_MIN : COMP_MAX;
  endfunction

  // Q3.30 to component grid, round half up, clamp to +-1.0.
  function automatic comp_t clamp_unit(input cval_t v);
    cval_t                   t;
    logic signed [CQ_W-1:0]  q;
    t = v + (CORDIC_W'(1) << (CQ_SHIFT - 1));
    q = t[CORDIC_W-1:CQ_SHIFT];
    if (q > CQ_W'(ONE_Q)) begin
      return COMP_WIDTH'(ONE_Q);
    end
    if (q < CQ_W'(-ONE_Q)) begin
      return COMP_WIDTH'(-ONE_Q);
    end
    return q[COMP_WIDTH-1:0];
  endfunction

endpackage

>>> sv/qau_if.sv
// Channel interfaces: request and response, valid/ready with payload.
interface qau_req_if;
  logic                     valid;
  logic                     ready;
  logic [1:0]               cmd;
  qau_pkg::comp_t           a_w;
  qau_pkg::comp_t           a_x;
  qau_pkg::comp_t           a_y;
  qau_pkg::comp_t           a_z;
  qau_pkg::comp_t           b_w;
  qau_pkg::comp_t           b_x;
  qau_pkg::comp_t           b_y;
  qau_pkg::comp_t           b_z;
  logic signed [15:0]       angle;
  modport source (output valid, cmd, a_w, a_x, a_y, a_z, b_w, b_x, b_y, b_z, angle,
                  input ready);
  modport sink (input valid, cmd, a_w, a_x, a_y, a_z, b_w, b_x, b_y, b_z, angle,
                output ready);
endinterface

interface qau_rsp_if;
  logic                               valid;
  logic                               ready;
  qau_pkg::comp_t                     r_w;
  qau_pkg::comp_t                     r_x;
  qau_pkg::comp_t                     r_y;
  qau_pkg::comp_t                     r_z;
  logic [qau_pkg::COMP_WIDTH-1:0]     norm_of_a;
  logic                               zero_error;
  modport source (output valid, r_w, r_x, r_y, r_z, norm_of_a, zero_error, input ready);
  modport sink (input valid, r_w, r_x, r_y, r_z, norm_of_a, zero_error, output ready);
endinterface

>>> sv/qau_sqrt.sv
// Pipelined integer square root, one result bit per stage.
module qau_sqrt (
  input  logic                           clk,
  input  logic                           en,
  input  logic [qau_pkg::SSUM_W-1:0]     value,
  output logic [qau_pkg::ROOT_W-1:0]     root
);

  logic [qau_pkg::SQRT_W-1:0] rem      [qau_pkg::SQRT_STEPS];
  logic [qau_pkg::SQRT_W-1:0] rt       [qau_pkg::SQRT_STEPS];
  logic [qau_pkg::SQRT_W-1:0] rem_next [qau_pkg::SQRT_STEPS];
  logic [qau_pkg::SQRT_W-1:0] rt_next  [qau_pkg::SQRT_STEPS];
  logic [qau_pkg::SQRT_W-1:0] cur_rem  [qau_pkg::SQRT_STEPS+1];
  logic [qau_pkg::SQRT_W-1:0] cur_rt   [qau_pkg::SQRT_STEPS+1];

  always_comb begin
    logic [qau_pkg::SQRT_W-1:0] bitv;
    logic [qau_pkg::SQRT_W-1:0] trial;
    cur_rem[0] = qau_pkg::SQRT_W'(value);
    cur_rt[0]  = '0;
    for (int k = 0; k < qau_pkg::SQRT_STEPS; k++) begin
      cur_rem[k+1] = rem[k];
      cur_rt[k+1]  = rt[k];
    end
    for (int k = 0; k < qau_pkg::SQRT_STEPS; k++) begin
      bitv  = qau_pkg::SQRT_W'(1) << (2 * (qau_pkg::SQRT_STEPS - 1 - k));
      trial = cur_rt[k] + bitv;
      if (cur_rem[k] >= trial) begin
        rem_next[k] = cur_rem[k] - trial;
        rt_next[k]  = (cur_rt[k] >> 1) + bitv;
      end else begin
        rem_next[k] = cur_rem[k];
        rt_next[k]  = cur_rt[k] >> 1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < qau_pkg::SQRT_STEPS; k++) begin
        rem[k] <= rem_next[k];
        rt[k]  <= rt_next[k];
      end
    end
  end

  assign root = rt[qau_pkg::SQRT_STEPS-1][qau_pkg::ROOT_W-1:0];

endmodule

>>> sv/qau_div.sv
// Pipelined restoring divider, four lanes sharing one divisor.
module qau_div (
  input  logic                        clk,
  input  logic                        en,
  input  logic [qau_pkg::NUM_W-1:0]   num   [4],
  input  logic [qau_pkg::ROOT_W-1:0]  den,
  output logic [qau_pkg::QUO_W-1:0]   quo   [4],
  output logic [qau_pkg::ROOT_W-1:0]  den_out
);

  logic [qau_pkg::ROOT_W-1:0] rem  [qau_pkg::DIV_STEPS][4];
  logic [qau_pkg::QUO_W-1:0]  low  [qau_pkg::DIV_STEPS][4];
  logic [qau_pkg::ROOT_W-1:0] dv   [qau_pkg::DIV_STEPS];
  logic [qau_pkg::ROOT_W-1:0] cur_rem  [qau_pkg::DIV_STEPS+1][4];
  logic [qau_pkg::QUO_W-1:0]  cur_low  [qau_pkg::DIV_STEPS+1][4];
  logic [qau_pkg::ROOT_W-1:0] cur_dv   [qau_pkg::DIV_STEPS+1];
  logic [qau_pkg::ROOT_W-1:0] rem_next [qau_pkg::DIV_STEPS][4];
  logic [qau_pkg::QUO_W-1:0]  low_next [qau_pkg::DIV_STEPS][4];

  always_comb begin
    logic [qau_pkg::ROOT_W:0] t;
    logic                     ge;
    for (int l = 0; l < 4; l++) begin
      cur_rem[0][l] = qau_pkg::ROOT_W'(num[l][qau_pkg::NUM_W-1:qau_pkg::QUO_W]);
      cur_low[0][l] = num[l][qau_pkg::QUO_W-1:0];
    end
    cur_dv[0] = den;
    for (int k = 0; k < qau_pkg::DIV_STEPS; k++) begin
      cur_rem[k+1] = rem[k];
      cur_low[k+1] = low[k];
      cur_dv[k+1]  = dv[k];
    end
    for (int k = 0; k < qau_pkg::DIV_STEPS; k++) begin
      for (int l = 0; l < 4; l++) begin
        t  = {cur_rem[k][l], cur_low[k][l][qau_pkg::QUO_W-1]};
        ge = (t >= {1'b0, cur_dv[k]});
        rem_next[k][l] = ge ? qau_pkg::ROOT_W'(t - {1'b0, cur_dv[k]})
                            : t[qau_pkg::ROOT_W-1:0];
        low_next[k][l] = {cur_low[k][l][qau_pkg::QUO_W-2:0], ge};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < qau_pkg::DIV_STEPS; k++) begin
        rem[k] <= rem_next[k];
        low[k] <= low_next[k];
        dv[k]  <= cur_dv[k];
      end
    end
  end

  assign quo     = low[qau_pkg::DIV_STEPS-1];
  assign den_out = dv[qau_pkg::DIV_STEPS-1];

endmodule

>>> sv/qau_cordic.sv
// Pipelined rotation-mode CORDIC, one micro-rotation per stage.
module qau_cordic (
  input  logic                                 clk,
  input  logic                                 en,
  input  logic signed [qau_pkg::ANGLE_W-1:0]   angle,
  output qau_pkg::cval_t                       cos_q,
  output qau_pkg::cval_t                       sin_q
);

  qau_pkg::cval_t x [qau_pkg::CORDIC_STEPS];
  qau_pkg::cval_t y [qau_pkg::CORDIC_STEPS];
  qau_pkg::cval_t z [qau_pkg::CORDIC_STEPS];
  qau_pkg::cval_t cx [qau_pkg::CORDIC_STEPS+1];
  qau_pkg::cval_t cy [qau_pkg::CORDIC_STEPS+1];
  qau_pkg::cval_t cz [qau_pkg::CORDIC_STEPS+1];
  qau_pkg::cval_t x_next [qau_pkg::CORDIC_STEPS];
  qau_pkg::cval_t y_next [qau_pkg::CORDIC_STEPS];
  qau_pkg::cval_t z_next [qau_pkg::CORDIC_STEPS];

  always_comb begin
    qau_pkg::cval_t dx;
    qau_pkg::cval_t dy;
    qau_pkg::cval_t at;
    cx[0] = qau_pkg::CORDIC_GAIN;
    cy[0] = '0;
    cz[0] = qau_pkg::cval_t'(angle) <<< qau_pkg::ANGLE_SHIFT;
    for (int k = 0; k < qau_pkg::CORDIC_STEPS; k++) begin
      cx[k+1] = x[k];
      cy[k+1] = y[k];
      cz[k+1] = z[k];
    end
    for (int k = 0; k < qau_pkg::CORDIC_STEPS; k++) begin
      dx = cy[k] >>> k;
      dy = cx[k] >>> k;
      at = $signed(qau_pkg::CORDIC_W'(qau_pkg::ATAN_TURNS[k]));
      if (!cz[k][qau_pkg::CORDIC_W-1]) begin
        x_next[k] = cx[k] - dx;
        y_next[k] = cy[k] + dy;
        z_next[k] = cz[k] - at;
      end else begin
        x_next[k] = cx[k] + dx;
        y_next[k] = cy[k] - dy;
        z_next[k] = cz[k] + at;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < qau_pkg::CORDIC_STEPS; k++) begin
        x[k] <= x_next[k];
        y[k] <= y_next[k];
        z[k] <= z_next[k];
      end
    end
  end

  assign cos_q = x[qau_pkg::CORDIC_STEPS-1];
  assign sin_q = y[qau_pkg::CORDIC_STEPS-1];

endmodule

>>> sv/quaternion_arithmetic_unit_top.sv
// Top level: quaternion unit pipeline with product, norm, divide, conjugate and CORDIC paths.
//
//   channel  dir  payload
//   req      in   cmd, a_w..a_z, b_w..b_z, angle
//   rsp      out  r_w..r_z, norm_of_a, zero_error
//
// One item per cycle while rsp is not stalled.
// The longest path runs through the 17-stage square root followed by the 15-stage divider.
// rst clears the valid bits of every stage and of the output register.
// A stall on rsp freezes all stages together; req.ready drops only then.
module quaternion_arithmetic_unit_top (
  input logic     clk,
  input logic     rst,
  qau_req_if.sink   req,
  qau_rsp_if.source rsp
);

  logic                               en;
  logic [qau_pkg::ST_LAST:1]          vld;
  qau_pkg::comp_t                     a_in [4];
  qau_pkg::comp_t                     b_in [4];

  logic [1:0]                         cmd1;
  qau_pkg::comp_t                     a1 [4];
  logic signed [qau_pkg::ANGLE_W-1:0] angle1;
  qau_pkg::prod_t                     prod1 [4][4];
  qau_pkg::prod_t                     sq1 [4];

  qau_pkg::pass_t                     pipe [qau_pkg::ST_SQRT_IN:qau_pkg::ST_LAST];
  logic [qau_pkg::SSUM_W-1:0]         ssum2;
  logic signed [qau_pkg::ANGLE_W-1:0] angle2;

  logic [qau_pkg::ROOT_W-1:0]         root;
  logic [qau_pkg::NUM_W-1:0]          num [4];
  logic [qau_pkg::QUO_W-1:0]          quo [4];
  logic [qau_pkg::ROOT_W-1:0]         den_out;
  qau_pkg::cval_t                     cos_q;
  qau_pkg::cval_t                     sin_q;

  qau_pkg::comp_t                     c27;
  qau_pkg::comp_t                     s27;
  qau_pkg::comp_t                     c28;
  qau_pkg::prod_t                     pa28 [4];
  qau_pkg::comp_t                     rax [qau_pkg::ST_COR_OUT+3:qau_pkg::ST_LAST][4];

  assign en        = !rsp.valid || rsp.ready;
  assign req.ready = en;

  assign a_in = '{req.a_w, req.a_x, req.a_y, req.a_z};
  assign b_in = '{req.b_w, req.b_x, req.b_y, req.b_z};

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[qau_pkg::ST_LAST-1:1], req.valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cmd1   <= req.cmd;
      a1     <= a_in;
      angle1 <= req.angle;
      for (int i = 0; i < 4; i++) begin
        sq1[i] <= a_in[i] * a_in[i];
        for (int j = 0; j < 4; j++) begin
          prod1[i][j] <= a_in[i] * b_in[j];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pipe[qau_pkg::ST_SQRT_IN].cmd <= cmd1;
      pipe[qau_pkg::ST_SQRT_IN].a   <= a1;
      pipe[qau_pkg::ST_SQRT_IN].rmul[0] <= qau_pkg::round_sat(
        qau_pkg::PSUM_W'(prod1[0][0]) - qau_pkg::PSUM_W'(prod1[1][1])
        - qau_pkg::PSUM_W'(prod1[2][2]) - qau_pkg::PSUM_W'(prod1[3][3]));
      pipe[qau_pkg::ST_SQRT_IN].rmul[1] <= qau_pkg::round_sat(
        qau_pkg::PSUM_W'(prod1[0][1]) + qau_pkg::PSUM_W'(prod1[1][0])
        + qau_pkg::PSUM_W'(prod1[2][3]) - qau_pkg::PSUM_W'(prod1[3][2]));
      pipe[qau_pkg::ST_SQRT_IN].rmul[2] <= qau_pkg::round_sat(
        qau_pkg::PSUM_W'(prod1[0][2]) - qau_pkg::PSUM_W'(prod1[1][3])
        + qau_pkg::PSUM_W'(prod1[2][0]) + qau_pkg::PSUM_W'(prod1[3][1]));
      pipe[qau_pkg::ST_SQRT_IN].rmul[3] <= qau_pkg::round_sat(
        qau_pkg::PSUM_W'(prod1[0][3]) + qau_pkg::PSUM_W'(prod1[1][2])
        - qau_pkg::PSUM_W'(prod1[2][1]) + qau_pkg::PSUM_W'(prod1[3][0]));
      pipe[qau_pkg::ST_SQRT_IN].rconj[0] <= a1[0];
      for (int i = 1; i < 4; i++) begin
        pipe[qau_pkg::ST_SQRT_IN].rconj[i] <= (a1[i] == qau_pkg::COMP_MIN) ?
                                              qau_pkg::COMP_MAX : -a1[i];
      end
      ssum2 <= {1'b0, sq1[0][qau_pkg::PROD_W-1:0]} + {1'b0, sq1[1][qau_pkg::PROD_W-1:0]}
             + {1'b0, sq1[2][qau_pkg::PROD_W-1:0]} + {1'b0, sq1[3][qau_pkg::PROD_W-1:0]};
      angle2 <= angle1;
      for (int k = qau_pkg::ST_SQRT_IN + 1; k <= qau_pkg::ST_LAST; k++) begin
        pipe[k] <= pipe[k-1];
      end
    end
  end

  qau_sqrt u_sqrt (
    .clk   (clk),
    .en    (en),
    .value (ssum2),
    .root  (root)
  );

  always_comb begin
    logic [qau_pkg::COMP_WIDTH-1:0] mag;
    for (int i = 0; i < 4; i++) begin
      mag    = pipe[qau_pkg::ST_DIV_IN].a[i][qau_pkg::COMP_WIDTH-1] ?
               qau_pkg::COMP_WIDTH'(-pipe[qau_pkg::ST_DIV_IN].a[i]) :
               qau_pkg::COMP_WIDTH'(pipe[qau_pkg::ST_DIV_IN].a[i]);
      num[i] = {mag, {qau_pkg::FRAC_BITS{1'b0}}} + qau_pkg::NUM_W'(root >> 1);
    end
  end

  qau_div u_div (
    .clk     (clk),
    .en      (en),
    .num     (num),
    .den     (root),
    .quo     (quo),
    .den_out (den_out)
  );

  qau_cordic u_cordic (
    .clk   (clk),
    .en    (en),
    .angle (angle2),
    .cos_q (cos_q),
    .sin_q (sin_q)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      c27 <= qau_pkg::clamp_unit(cos_q);
      s27 <= qau_pkg::clamp_unit(sin_q);
      c28 <= c27;
      for (int i = 0; i < 4; i++) begin
        pa28[i] <= pipe[qau_pkg::ST_COR_OUT+1].a[i] * s27;
      end
      rax[qau_pkg::ST_COR_OUT+3][0] <= c28;
      for (int i = 1; i < 4; i++) begin
        rax[qau_pkg::ST_COR_OUT+3][i] <= qau_pkg::round_sat(qau_pkg::PSUM_W'(pa28[i]));
      end
      for (int k = qau_pkg::ST_COR_OUT + 4; k <= qau_pkg::ST_LAST; k++) begin
        rax[k] <= rax[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (en) begin
      rsp.valid <= vld[qau_pkg::ST_LAST];
    end
  end

  always_ff @(posedge clk) begin
    qau_pkg::comp_t r [4];
    logic           zerr;
    r    = '{default: '0};
    zerr = 1'b0;
    unique case (pipe[qau_pkg::ST_LAST].cmd)
      qau_pkg::CMD_MUL: begin
        r = pipe[qau_pkg::ST_LAST].rmul;
      end
      qau_pkg::CMD_NORM: begin
        if (den_out == '0) begin
          zerr = 1'b1;
        end else begin
          for (int i = 0; i < 4; i++) begin
            r[i] = pipe[qau_pkg::ST_LAST].a[i][qau_pkg::COMP_WIDTH-1] ?
                   -qau_pkg::comp_t'(quo[i]) : qau_pkg::comp_t'(quo[i]);
          end
        end
      end
      qau_pkg::CMD_CONJ: begin
        r = pipe[qau_pkg::ST_LAST].rconj;
      end
      qau_pkg::CMD_AXIS: begin
        r = rax[qau_pkg::ST_LAST];
      end
      default: begin
        r = '{default: '0};
      end
    endcase
    if (en) begin
      rsp.r_w        <= r[0];
      rsp.r_x        <= r[1];
      rsp.r_y        <= r[2];
      rsp.r_z        <= r[3];
      rsp.zero_error <= zerr;
      rsp.norm_of_a  <= den_out[qau_pkg::ROOT_W-1] ? '1 : den_out[qau_pkg::COMP_WIDTH-1:0];
    end
  end

`ifndef SYNTHESIS
  a_zero_err_clears: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.zero_error |->
      rsp.r_w == 0 && rsp.r_x == 0 && rsp.r_y == 0 && rsp.r_z == 0)
    else $error("zero_error with nonzero result");

  a_zero_err_norm: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.zero_error |-> rsp.norm_of_a == 0)
    else $error("zero_error with nonzero norm");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !rsp.valid && vld == '0)
    else $error("pipeline not empty after reset");
`endif

endmodule
